>>> hw/rtl/r2h_pkg.sv
// shared types, constants and the reciprocal table for the rgb to hsv converter
package r2h_pkg;

    localparam int CHAN_W   = 8;
    localparam int HUE_W    = 15;
    localparam int HNUM_W   = 20;   // 3840 * 255 fits in 20 bits
    localparam int SNUM_W   = 16;   // 255 * 255 fits in 16 bits
    localparam int RECIP_K  = 20;   // reciprocal scale 2^20, no smaller than the widest numerator
    localparam int RECIP_W  = RECIP_K + 1;
    localparam int HQ_W     = 12;   // hue quotient never exceeds 3840
    localparam int R2H_QUEUE_DEPTH = 4;

    localparam logic [HUE_W-1:0] HUE_SEXTANT = 15'd3840;
    localparam logic [HUE_W-1:0] HUE_FULL    = 15'd23040;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // classified pixel handed from the front to the back
    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic [CHAN_W-1:0]   mag;
        logic [CHAN_W-1:0]   delta;
        logic [CHAN_W-1:0]   bright;
    } item_t;

    typedef logic [RECIP_W-1:0] recip_tab_t [256];

    // floor(2^RECIP_K / d) by long division, entry zero unused
    function automatic recip_tab_t build_recip_tab();
        recip_tab_t          tab;
        logic [RECIP_W:0]    rem;
        logic [RECIP_W-1:0]  quo;
        logic [RECIP_W-1:0]  one;
        tab[0] = '0;
        one = RECIP_W'(1) << RECIP_K;
        for (int d = 1; d < 256; d++) begin
            rem = '0;
            quo = '0;
            for (int b = RECIP_W - 1; b >= 0; b--) begin
                rem = {rem[RECIP_W-1:0], one[b]};
                if (rem >= (RECIP_W+1)'(d)) begin
                    rem = rem - (RECIP_W+1)'(d);
                    quo[b] = 1'b1;
                end
            end
            tab[d] = quo;
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip_tab();

endpackage

>>> hw/rtl/r2h_front.sv
// front end: accepts pixels, finds max, min, delta and the hue sector
module r2h_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // red, green, blue from bit 0 up
    output logic                   push_valid,
    input  logic                   push_ready,
    output r2h_pkg::item_t         push_item
);
    import r2h_pkg::*;

    logic              front_valid_reg;
    item_t             item_reg;
    item_t             item_next;
    logic [CHAN_W-1:0] red, green, blue;
    logic [CHAN_W-1:0] mx, mn;
    logic [CHAN_W:0]   diff;

    assign red   = s_tdata[7:0];
    assign green = s_tdata[15:8];
    assign blue  = s_tdata[23:16];

    always_comb begin
        mx = (red > green) ? red : green;
        mn = (red < green) ? red : green;
        if (blue > mx) mx = blue;
        if (blue < mn) mn = blue;
        if (red >= mx) begin
            item_next.sector = SECT_RED;
            diff = {1'b0, green} - {1'b0, blue};
        end else if (green >= mx) begin
            item_next.sector = SECT_GREEN;
            diff = {1'b0, blue} - {1'b0, red};
        end else begin
            item_next.sector = SECT_BLUE;
            diff = {1'b0, red} - {1'b0, green};
        end
        item_next.neg    = diff[CHAN_W];
        item_next.mag    = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        item_next.delta  = mx - mn;
        item_next.bright = mx;
    end

    assign s_tready   = !front_valid_reg || push_ready;
    assign push_valid = front_valid_reg;
    assign push_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (s_tready) begin
            front_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> hw/rtl/r2h_queue.sv
// short fifo of classified pixels between front and back
module r2h_queue #(
    parameter int DEPTH = r2h_pkg::R2H_QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  r2h_pkg::item_t  in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output r2h_pkg::item_t  out_item
);
    import r2h_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    item_t             mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> hw/rtl/r2h_back.sv
// back end: reciprocal divide pipeline for saturation and hue
module r2h_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  r2h_pkg::item_t  pop_item,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [31:0]     m_tdata    // hue, saturation, brightness from bit 0 up, pad bit
);
    import r2h_pkg::*;

    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic [CHAN_W-1:0]   delta;
        logic [CHAN_W-1:0]   bright;
        logic [HNUM_W-1:0]   hnum;
        logic [SNUM_W-1:0]   snum;
    } stage_t;

    logic                adv;
    logic                v1_reg, v2_reg, v3_reg, out_valid_reg;
    stage_t              st1_reg, st2_reg, st3_reg;
    stage_t              st1_next;
    logic [RECIP_W-1:0]  recip_d_reg, recip_m_reg;
    logic [HQ_W-1:0]     qh2_reg, qh3_reg;
    logic [CHAN_W-1:0]   qs2_reg, qs3_reg;
    logic [HNUM_W-1:0]   backh3_reg;
    logic [SNUM_W-1:0]   backs3_reg;
    logic [HNUM_W+RECIP_W-1:0] hprod;
    logic [SNUM_W+RECIP_W-1:0] sprod;
    logic [HNUM_W-1:0]   remh;
    logic [SNUM_W-1:0]   rems;
    logic [HQ_W-1:0]     qh_fix;
    logic [CHAN_W-1:0]   qs_fix;
    logic [HUE_W-1:0]    hue_next, hue_reg;
    logic [CHAN_W-1:0]   sat_next, sat_reg, bright_reg;

    // whole pipeline moves when the output register is free or being taken
    assign adv       = !out_valid_reg || m_tready;
    assign pop_ready = adv;

    always_comb begin
        st1_next.sector = pop_item.sector;
        st1_next.neg    = pop_item.neg;
        st1_next.delta  = pop_item.delta;
        st1_next.bright = pop_item.bright;
        // 3840 * mag and 255 * delta as shift and subtract
        st1_next.hnum   = {pop_item.mag, 12'b0} - {4'b0, pop_item.mag, 8'b0};
        st1_next.snum   = {pop_item.delta, 8'b0} - {8'b0, pop_item.delta};
    end

    assign hprod = (HNUM_W+RECIP_W)'(st1_reg.hnum) * (HNUM_W+RECIP_W)'(recip_d_reg);
    assign sprod = (SNUM_W+RECIP_W)'(st1_reg.snum) * (SNUM_W+RECIP_W)'(recip_m_reg);

    // quotient estimate is exact or one low, one compare fixes it
    always_comb begin
        remh   = st3_reg.hnum - backh3_reg;
        rems   = st3_reg.snum - backs3_reg;
        qh_fix = qh3_reg + HQ_W'(remh >= HNUM_W'(st3_reg.delta));
        qs_fix = qs3_reg + CHAN_W'(rems >= SNUM_W'(st3_reg.bright));
        unique case (st3_reg.sector)
            SECT_RED: begin
                hue_next = st3_reg.neg ? HUE_FULL - HUE_W'(qh_fix) : HUE_W'(qh_fix);
            end
            SECT_GREEN: begin
                hue_next = st3_reg.neg ? (HUE_SEXTANT << 1) - HUE_W'(qh_fix)
                                       : (HUE_SEXTANT << 1) + HUE_W'(qh_fix);
            end
            SECT_BLUE: begin
                hue_next = st3_reg.neg ? (HUE_SEXTANT << 2) - HUE_W'(qh_fix)
                                       : (HUE_SEXTANT << 2) + HUE_W'(qh_fix);
            end
            default: begin
                hue_next = '0;
            end
        endcase
        sat_next = qs_fix;
        if (st3_reg.delta == '0) begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= pop_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg     <= st1_next;
            recip_d_reg <= RECIP_TAB[pop_item.delta];
            recip_m_reg <= RECIP_TAB[pop_item.bright];

            st2_reg     <= st1_reg;
            qh2_reg     <= hprod[RECIP_K +: HQ_W];
            qs2_reg     <= sprod[RECIP_K +: CHAN_W];

            st3_reg     <= st2_reg;
            qh3_reg     <= qh2_reg;
            qs3_reg     <= qs2_reg;
            backh3_reg  <= HNUM_W'(qh2_reg) * HNUM_W'(st2_reg.delta);
            backs3_reg  <= SNUM_W'(qs2_reg) * SNUM_W'(st2_reg.bright);

            hue_reg     <= hue_next;
            sat_reg     <= sat_next;
            bright_reg  <= st3_reg.bright;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, bright_reg, sat_reg, hue_reg};

endmodule

>>> hw/rtl/rgb_to_hsv_convert.sv
// top level of the streaming rgb to hsv pixel converter
// converts one 8-bit rgb pixel per beat into hue (1/64 degree, 0..23039),
// saturation floor(255*delta/max) and brightness (largest channel); grey
// pixels give hue and saturation zero. one pixel is taken every clock
// cycle in sustained flow while results are not stalled, set by the back
// end pipeline which retires one beat per cycle through its reciprocal
// multiply stages while it can advance. an accepted input beat reaches its
// result beat through the classify register, the queue and the four
// registers of the divide pipeline. the front keeps accepting while
// results stall, until the queue fills.
module rgb_to_hsv_convert #(
    parameter int QUEUE_DEPTH = r2h_pkg::R2H_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // red [7:0], green [15:8], blue [23:16]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // hue [14:0], saturation [22:15], brightness [30:23], zero
);
    import r2h_pkg::*;

    // classified pixel leaving the front
    logic  push_valid, push_ready;
    item_t push_item;

    // classified pixel entering the back
    logic  pop_valid, pop_ready;
    item_t pop_item;

    // max, min, delta and hue sector, one register stage
    r2h_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decouples front from back so each side can stall on its own
    r2h_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_item  (pop_item)
    );

    // reciprocal divide for saturation and hue, output register last
    r2h_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

>>> tb/tb.sv
// self-checking stream testbench for the rgb to hsv pixel converter
`timescale 1ns / 1ps

module tb;
    import r2h_pkg::*;

    localparam int SEXTANT   = int'(HUE_SEXTANT);
    localparam int FULL_TURN = int'(HUE_FULL);

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct {
        rgb_t pix;
        bit   drain_first;  // hold this pixel until every result is back
    } pending_pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bright;
    } hsv_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    pending_pixel_t pixel_queue[$];
    hsv_t           hsv_expected[$];

    int send_gap   = 0;
    int recv_gap   = 0;
    int sent_beats = 0;
    int recv_beats = 0;
    int errors     = 0;

    rgb_to_hsv_convert uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // expected hue, saturation and brightness of one pixel
    function automatic hsv_t hsv_of(rgb_t p);
        int      r, g, b, top, bottom, delta, diff, part, hue;
        sector_t sect;
        hsv_t    res;
        r = p.red;
        g = p.green;
        b = p.blue;
        top    = (r > g) ? r : g;
        bottom = (r < g) ? r : g;
        if (b > top)    top = b;
        if (b < bottom) bottom = b;
        delta = top - bottom;
        res.bright = CHAN_W'(top);
        if (delta == 0) begin
            // grey, black included: no hue, no saturation
            res.hue = '0;
            res.sat = '0;
            return res;
        end
        res.sat = CHAN_W'((delta * 255) / top);
        // ties go to red first, then green
        if (r >= top) begin
            sect = SECT_RED;
            diff = g - b;
        end else if (g >= top) begin
            sect = SECT_GREEN;
            diff = b - r;
        end else begin
            sect = SECT_BLUE;
            diff = r - g;
        end
        // truncate toward zero
        part = ((diff < 0 ? -diff : diff) * SEXTANT) / delta;
        if (diff < 0) part = -part;
        case (sect)
            SECT_RED: begin
                hue = part;
                if (hue < 0) hue += FULL_TURN;
            end
            SECT_GREEN: hue = 2 * SEXTANT + part;
            default:    hue = 4 * SEXTANT + part;
        endcase
        res.hue = HUE_W'(hue);
        return res;
    endfunction

    // mostly back to back, some short gaps, a few long ones, with stretches of no gaps
    function automatic int pick_gap(int beats);
        int roll;
        if ((beats / 80) % 4 == 1) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [CHAN_W-1:0] corner_value();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    function automatic rgb_t random_pixel();
        rgb_t              p;
        logic [CHAN_W-1:0] v;
        int                base;
        p = rgb_t'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                // grey
                v = CHAN_W'($urandom);
                p = '{v, v, v};
            end
            1: p = '{corner_value(), corner_value(), corner_value()};
            2: begin
                // two channels share the maximum
                v = CHAN_W'($urandom_range(1, 255));
                p = '{CHAN_W'($urandom_range(0, v)), v, v};
                case ($urandom_range(0, 2))
                    0:       p = '{p.blue, p.green, p.red};
                    1:       p = '{p.green, p.blue, p.red};
                    default: p = '{p.green, p.red, p.blue};
                endcase
            end
            3: begin
                // near grey, small delta
                base = $urandom_range(0, 252);
                p = '{CHAN_W'(base + $urandom_range(0, 3)),
                      CHAN_W'(base + $urandom_range(0, 3)),
                      CHAN_W'(base + $urandom_range(0, 3))};
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic queue_pixel(int r, int g, int b, bit drain);
        pending_pixel_t item;
        item.pix = '{CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
        item.drain_first = drain;
        pixel_queue.push_back(item);
    endtask

    task automatic report_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // pixel driver
    always @(posedge aclk) begin
        pending_pixel_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                hsv_expected.push_back(hsv_of(rgb_t'(s_tdata)));
                sent_beats++;
            end
            // free to present a new beat unless the current one is still held
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pixel_queue.size() != 0 &&
                             !(pixel_queue[0].drain_first && hsv_expected.size() != 0)) begin
                    item = pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.pix;
                    send_gap = pick_gap(sent_beats);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and back pressure
    always @(posedge aclk) begin
        hsv_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                recv_beats++;
                if (hsv_expected.size() == 0) begin
                    $display("%0t ns: result expected none actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = hsv_expected.pop_front();
                    report_field("hue", want.hue, m_tdata[14:0]);
                    report_field("saturation", want.sat, m_tdata[22:15]);
                    report_field("brightness", want.bright, m_tdata[30:23]);
                    report_field("pad bit", 0, m_tdata[31]);
                end
                recv_gap = pick_gap(recv_beats);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        // directed: extremes, primaries, ties, wraparound and grey cases
        queue_pixel(0, 0, 0, 1'b0);         // black
        queue_pixel(255, 255, 255, 1'b0);   // white
        queue_pixel(128, 128, 128, 1'b0);   // mid grey
        queue_pixel(255, 0, 0, 1'b0);
        queue_pixel(0, 255, 0, 1'b0);
        queue_pixel(0, 0, 255, 1'b0);
        queue_pixel(255, 255, 0, 1'b0);     // red and green tie
        queue_pixel(0, 255, 255, 1'b0);     // green and blue tie
        queue_pixel(255, 0, 255, 1'b0);     // red and blue tie
        queue_pixel(255, 0, 1, 1'b0);       // red hue just below a full turn
        queue_pixel(255, 0, 254, 1'b0);
        queue_pixel(1, 0, 0, 1'b0);         // smallest nonzero max
        queue_pixel(0, 0, 1, 1'b0);
        queue_pixel(0, 1, 0, 1'b0);
        queue_pixel(255, 254, 254, 1'b0);   // smallest delta
        queue_pixel(254, 255, 0, 1'b0);
        queue_pixel(0, 254, 255, 1'b0);
        queue_pixel(85, 170, 255, 1'b0);
        queue_pixel(1, 2, 3, 1'b0);
        queue_pixel(3, 2, 1, 1'b0);
        queue_pixel(8'haa, 8'h55, 8'haa, 1'b0);
        queue_pixel(8'h55, 8'haa, 8'h55, 1'b0);
        // random, with a full drain before the first and in the middle
        for (int i = 0; i < 900; i++) begin
            pending_pixel_t item;
            item.pix = random_pixel();
            item.drain_first = (i == 0) || (i == 450);
            pixel_queue.push_back(item);
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pixel_queue.size() != 0 || s_tvalid || hsv_expected.size() != 0)
            @(posedge aclk);
        // catch stray beats after the last expected one
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #1000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
